[rtl/cafu_pkg.sv]
// shared types and operation codes for the 8-bit alu and flags unit
package cafu_pkg;

	// operation codes
	localparam logic [4:0] MODE_ADD  = 5'd0;
	localparam logic [4:0] MODE_ADC  = 5'd1;
	localparam logic [4:0] MODE_SUB  = 5'd2;
	localparam logic [4:0] MODE_SBC  = 5'd3;
	localparam logic [4:0] MODE_AND  = 5'd4;
	localparam logic [4:0] MODE_XOR  = 5'd5;
	localparam logic [4:0] MODE_OR   = 5'd6;
	localparam logic [4:0] MODE_CP   = 5'd7;
	localparam logic [4:0] MODE_INC  = 5'd8;
	localparam logic [4:0] MODE_DEC  = 5'd9;
	localparam logic [4:0] MODE_RLCA = 5'd10;
	localparam logic [4:0] MODE_RRCA = 5'd11;
	localparam logic [4:0] MODE_RLA  = 5'd12;
	localparam logic [4:0] MODE_RRA  = 5'd13;
	localparam logic [4:0] MODE_RLC  = 5'd14;
	localparam logic [4:0] MODE_RRC  = 5'd15;
	localparam logic [4:0] MODE_RL   = 5'd16;
	localparam logic [4:0] MODE_RR   = 5'd17;
	localparam logic [4:0] MODE_SLA  = 5'd18;
	localparam logic [4:0] MODE_SRA  = 5'd19;
	localparam logic [4:0] MODE_SWAP = 5'd20;
	localparam logic [4:0] MODE_SRL  = 5'd21;
	localparam logic [4:0] MODE_BIT  = 5'd22;
	localparam logic [4:0] MODE_RES  = 5'd23;
	localparam logic [4:0] MODE_SET  = 5'd24;
	localparam logic [4:0] MODE_DAA  = 5'd25;
	localparam logic [4:0] MODE_CPL  = 5'd26;
	localparam logic [4:0] MODE_SCF  = 5'd27;
	localparam logic [4:0] MODE_CCF  = 5'd28;
	localparam logic [4:0] MODE_ADDW = 5'd29;
	localparam logic [4:0] MODE_ADDSP = 5'd30;

	// flag bit positions within the 4-bit flag word
	localparam int FLAG_Z = 3;
	localparam int FLAG_N = 2;
	localparam int FLAG_H = 1;
	localparam int FLAG_C = 0;

	// decimal adjust constants
	localparam logic [7:0] DAA_LO_ADJ  = 8'h06;
	localparam logic [7:0] DAA_HI_ADJ  = 8'h60;
	localparam logic [7:0] DAA_ACC_MAX = 8'h99;
	localparam logic [3:0] DAA_NIB_MAX = 4'h9;

	// stream widths
	localparam int IN_DATA_W  = 64;
	localparam int OUT_DATA_W = 32;

	// one operation item
	typedef struct packed {
		logic [4:0]  mode;
		logic [7:0]  acc;
		logic [7:0]  operand;
		logic [2:0]  bit_index;
		logic [3:0]  flags_in;
		logic [15:0] wide_left;
		logic [15:0] wide_right;
	} alu_in_t;

	// one result item
	typedef struct packed {
		logic [3:0]  flags_out;
		logic [15:0] result_wide;
		logic [7:0]  result_byte;
	} alu_out_t;

endpackage

[rtl/cafu_core.sv]
// combinational alu: arithmetic, logic, shifts, bit ops, decimal adjust and 16-bit adds
module cafu_core (
	input  cafu_pkg::alu_in_t  op,
	output cafu_pkg::alu_out_t res
);

	logic [7:0]  a, d;
	logic        ci, zi, ni, hi;
	logic [7:0]  rb;
	logic [15:0] rw;
	logic [3:0]  fo;

	logic        cin_add, cin_sub;
	logic [7:0]  nd;
	logic [8:0]  add_r, sub_r;
	logic [4:0]  add_lo, sub_lo;
	logic [16:0] w_r;
	logic [12:0] w_lo;
	logic [15:0] sp_r;
	logic [4:0]  sp_lo;
	logic [8:0]  sp_byte;
	logic [7:0]  daa_t;
	logic [8:0]  daa_r;

	assign a  = op.acc;
	assign d  = op.operand;
	assign zi = op.flags_in[cafu_pkg::FLAG_Z];
	assign ni = op.flags_in[cafu_pkg::FLAG_N];
	assign hi = op.flags_in[cafu_pkg::FLAG_H];
	assign ci = op.flags_in[cafu_pkg::FLAG_C];

	// 8-bit adder with optional carry in
	assign cin_add = (op.mode == cafu_pkg::MODE_ADC) && ci;
	assign add_r   = {1'b0, a} + {1'b0, d} + {8'd0, cin_add};
	assign add_lo  = {1'b0, a[3:0]} + {1'b0, d[3:0]} + {4'd0, cin_add};

	// subtract as add of the complement, borrow is inverted carry
	assign nd      = ~d;
	assign cin_sub = !((op.mode == cafu_pkg::MODE_SBC) && ci);
	assign sub_r   = {1'b0, a} + {1'b0, nd} + {8'd0, cin_sub};
	assign sub_lo  = {1'b0, a[3:0]} + {1'b0, nd[3:0]} + {4'd0, cin_sub};

	// 16-bit register pair add
	assign w_r  = {1'b0, op.wide_left} + {1'b0, op.wide_right};
	assign w_lo = {1'b0, op.wide_left[11:0]} + {1'b0, op.wide_right[11:0]};

	// stack pointer plus signed byte, flags from the low byte
	assign sp_r    = op.wide_left + {{8{d[7]}}, d};
	assign sp_lo   = {1'b0, op.wide_left[3:0]} + {1'b0, d[3:0]};
	assign sp_byte = {1'b0, op.wide_left[7:0]} + {1'b0, d};

	// decimal adjust correction
	always_comb begin
		if (ni) begin
			daa_t = (hi ? cafu_pkg::DAA_LO_ADJ : 8'h00) + (ci ? cafu_pkg::DAA_HI_ADJ : 8'h00);
		end else begin
			daa_t = ((hi || (a[3:0] > cafu_pkg::DAA_NIB_MAX)) ? cafu_pkg::DAA_LO_ADJ : 8'h00)
				+ ((ci || (a > cafu_pkg::DAA_ACC_MAX)) ? cafu_pkg::DAA_HI_ADJ : 8'h00);
		end
	end
	assign daa_r = ni ? ({1'b0, a} - {1'b0, daa_t}) : ({1'b0, a} + {1'b0, daa_t});

	// result and flag selection by operation
	always_comb begin
		rb = a;
		rw = 16'h0000;
		fo = op.flags_in;
		case (op.mode)
			cafu_pkg::MODE_ADD, cafu_pkg::MODE_ADC: begin
				rb = add_r[7:0];
				fo = {add_r[7:0] == 8'h00, 1'b0, add_lo[4], add_r[8]};
			end
			cafu_pkg::MODE_SUB, cafu_pkg::MODE_SBC: begin
				rb = sub_r[7:0];
				fo = {sub_r[7:0] == 8'h00, 1'b1, !sub_lo[4], !sub_r[8]};
			end
			cafu_pkg::MODE_CP: begin
				fo = {sub_r[7:0] == 8'h00, 1'b1, !sub_lo[4], !sub_r[8]};
			end
			cafu_pkg::MODE_AND: begin
				rb = a & d;
				fo = {(a & d) == 8'h00, 1'b0, 1'b1, 1'b0};
			end
			cafu_pkg::MODE_XOR: begin
				rb = a ^ d;
				fo = {(a ^ d) == 8'h00, 1'b0, 1'b0, 1'b0};
			end
			cafu_pkg::MODE_OR: begin
				rb = a | d;
				fo = {(a | d) == 8'h00, 1'b0, 1'b0, 1'b0};
			end
			cafu_pkg::MODE_INC: begin
				rb = d + 8'd1;
				fo = {d == 8'hFF, 1'b0, d[3:0] == 4'hF, ci};
			end
			cafu_pkg::MODE_DEC: begin
				rb = d - 8'd1;
				fo = {d == 8'h01, 1'b1, d[3:0] == 4'h0, ci};
			end
			cafu_pkg::MODE_RLCA: begin
				rb = {a[6:0], a[7]};
				fo = {3'b000, a[7]};
			end
			cafu_pkg::MODE_RRCA: begin
				rb = {a[0], a[7:1]};
				fo = {3'b000, a[0]};
			end
			cafu_pkg::MODE_RLA: begin
				rb = {a[6:0], ci};
				fo = {3'b000, a[7]};
			end
			cafu_pkg::MODE_RRA: begin
				rb = {ci, a[7:1]};
				fo = {3'b000, a[0]};
			end
			cafu_pkg::MODE_RLC: begin
				rb = {d[6:0], d[7]};
				fo = {rb == 8'h00, 2'b00, d[7]};
			end
			cafu_pkg::MODE_RRC: begin
				rb = {d[0], d[7:1]};
				fo = {rb == 8'h00, 2'b00, d[0]};
			end
			cafu_pkg::MODE_RL: begin
				rb = {d[6:0], ci};
				fo = {rb == 8'h00, 2'b00, d[7]};
			end
			cafu_pkg::MODE_RR: begin
				rb = {ci, d[7:1]};
				fo = {rb == 8'h00, 2'b00, d[0]};
			end
			cafu_pkg::MODE_SLA: begin
				rb = {d[6:0], 1'b0};
				fo = {rb == 8'h00, 2'b00, d[7]};
			end
			cafu_pkg::MODE_SRA: begin
				rb = {d[7], d[7:1]};
				fo = {rb == 8'h00, 2'b00, d[0]};
			end
			cafu_pkg::MODE_SWAP: begin
				rb = {d[3:0], d[7:4]};
				fo = {d == 8'h00, 3'b000};
			end
			cafu_pkg::MODE_SRL: begin
				rb = {1'b0, d[7:1]};
				fo = {rb == 8'h00, 2'b00, d[0]};
			end
			cafu_pkg::MODE_BIT: begin
				fo = {!d[op.bit_index], 1'b0, 1'b1, ci};
			end
			cafu_pkg::MODE_RES: begin
				rb = d & ~(8'd1 << op.bit_index);
			end
			cafu_pkg::MODE_SET: begin
				rb = d | (8'd1 << op.bit_index);
			end
			cafu_pkg::MODE_DAA: begin
				rb = daa_r[7:0];
				fo = {daa_r[7:0] == 8'h00, ni, 1'b0, ci || (!ni && daa_r[8])};
			end
			cafu_pkg::MODE_CPL: begin
				rb = ~a;
				fo = {zi, 1'b1, 1'b1, ci};
			end
			cafu_pkg::MODE_SCF: begin
				fo = {zi, 1'b0, 1'b0, 1'b1};
			end
			cafu_pkg::MODE_CCF: begin
				fo = {zi, 1'b0, 1'b0, !ci};
			end
			cafu_pkg::MODE_ADDW: begin
				rw = w_r[15:0];
				fo = {zi, 1'b0, w_lo[12], w_r[16]};
			end
			cafu_pkg::MODE_ADDSP: begin
				rw = sp_r;
				fo = {2'b00, sp_lo[4], sp_byte[8]};
			end
			default: begin
				// unused code passes accumulator and flags through
				rb = a;
			end
		endcase
	end

	assign res.result_byte = rb;
	assign res.result_wide = rw;
	assign res.flags_out   = fo;

endmodule

[rtl/cpu_8bit_alu_flags_unit.sv]
// top level: input register, alu and result register with stream handshakes
//
// channel | dir | width | contents
// s_*     | in  | 64    | one operation item per accepted beat
// m_*     | out | 32    | one result item per accepted beat
//
// one item per cycle sustained while m_tready is high; an accepted item is captured in
// the input register and then moves into the result register, which presents it.
// arst_n clears both stage valid bits; payload registers are not reset.
// with m_tready low the result register holds, and the input register still
// takes one more item before s_tready drops.
module cpu_8bit_alu_flags_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// mode[4:0], acc[12:5], operand[20:13], bit_index[23:21], flags_in[27:24],
	// wide_left[43:28], wide_right[59:44], zero[63:60]
	input  logic [cafu_pkg::IN_DATA_W-1:0]  s_tdata,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// result_byte[7:0], result_wide[23:8], flags_out[27:24], zero[31:28]
	output logic [cafu_pkg::OUT_DATA_W-1:0] m_tdata
);

	logic               valid_s1, valid_s2;
	logic               adv_s1;
	cafu_pkg::alu_in_t  op_s1;
	cafu_pkg::alu_out_t res_comb;
	cafu_pkg::alu_out_t res_s2;

	// stage advance control
	assign adv_s1   = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || adv_s1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1.mode       <= s_tdata[4:0];
			op_s1.acc        <= s_tdata[12:5];
			op_s1.operand    <= s_tdata[20:13];
			op_s1.bit_index  <= s_tdata[23:21];
			op_s1.flags_in   <= s_tdata[27:24];
			op_s1.wide_left  <= s_tdata[43:28];
			op_s1.wide_right <= s_tdata[59:44];
		end
	end

	// alu
	cafu_core u_core (
		.op  (op_s1),
		.res (res_comb)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && valid_s1) begin
			res_s2 <= res_comb;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {4'b0000, res_s2.flags_out, res_s2.result_wide, res_s2.result_byte};

	// input is only refused when both stages are occupied
	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (valid_s1 && valid_s2))
		else $error("s_tready low with a free stage");

	// an accepted item lands in the input register
	a_accept_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> valid_s1)
		else $error("accepted item not held in input register");

	// an item in the input register moves on when the result side is free
	a_move_s2: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && adv_s1) |=> valid_s2)
		else $error("item lost between input and result register");

	// an item held behind a stalled result is kept
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && !m_tready) |=> (valid_s1 && $stable(op_s1)))
		else $error("waiting item dropped or changed during stall");

endmodule

[verif/tb.sv]
// self-checking testbench for the 8-bit alu and flags unit
`timescale 1ns / 1ps

module tb;

	// mode code with no operation behind it
	localparam logic [4:0] MODE_SPARE = 5'd31;
	localparam int RANDOM_ITEMS = 1550;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int HOLD_CYCLES  = 60;

	// one directed row: operation item plus an optional typed-in result
	typedef struct {
		cafu_pkg::alu_in_t  op;
		bit                 typed;
		cafu_pkg::alu_out_t want;
	} vec_t;

	logic                            clk      = 1'b0;
	logic                            arst_n   = 1'b0;
	logic                            s_tvalid = 1'b0;
	logic                            s_tready;
	logic [cafu_pkg::IN_DATA_W-1:0]  s_tdata  = '0;
	logic                            m_tvalid;
	logic                            m_tready = 1'b0;
	logic [cafu_pkg::OUT_DATA_W-1:0] m_tdata;

	cafu_pkg::alu_out_t pending_results[$];
	int                 mismatch_count = 0;
	int                 cycle_count    = 0;
	bit                 steady_phase   = 1'b0;

	cpu_8bit_alu_flags_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		// mode, acc, operand, bit_index, flags_in, wide_left, wide_right, zero
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		// result_byte, result_wide, flags_out, zero
		.m_tdata  (m_tdata)
	);

	// 20 ns clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic [3:0] flag_word(input logic z, input logic n,
			input logic h, input logic c);
		return {z, n, h, c};
	endfunction

	// expected result of one operation item
	function automatic cafu_pkg::alu_out_t predict_alu(input cafu_pkg::alu_in_t op);
		cafu_pkg::alu_out_t res;
		logic [8:0]  sum9;
		logic [4:0]  nib;
		logic [16:0] sum17;
		logic [12:0] low13;
		logic [7:0]  v;
		logic [7:0]  inv;
		logic [7:0]  adj;
		logic        cin;
		logic        co;
		logic        zi;
		logic        ni;
		logic        hi;
		logic        ci;
		zi = op.flags_in[cafu_pkg::FLAG_Z];
		ni = op.flags_in[cafu_pkg::FLAG_N];
		hi = op.flags_in[cafu_pkg::FLAG_H];
		ci = op.flags_in[cafu_pkg::FLAG_C];
		res.result_byte = op.acc;
		res.result_wide = '0;
		res.flags_out   = op.flags_in;
		case (op.mode)
			cafu_pkg::MODE_ADD, cafu_pkg::MODE_ADC: begin
				cin  = (op.mode == cafu_pkg::MODE_ADC) && ci;
				sum9 = {1'b0, op.acc} + {1'b0, op.operand} + {8'd0, cin};
				nib  = {1'b0, op.acc[3:0]} + {1'b0, op.operand[3:0]} + {4'd0, cin};
				res.result_byte = sum9[7:0];
				res.flags_out = flag_word(sum9[7:0] == 8'd0, 1'b0, nib[4], sum9[8]);
			end
			// subtract as add of the inverse; borrow is the missing carry
			cafu_pkg::MODE_SUB, cafu_pkg::MODE_SBC, cafu_pkg::MODE_CP: begin
				cin  = !((op.mode == cafu_pkg::MODE_SBC) && ci);
				inv  = ~op.operand;
				sum9 = {1'b0, op.acc} + {1'b0, inv} + {8'd0, cin};
				nib  = {1'b0, op.acc[3:0]} + {1'b0, inv[3:0]} + {4'd0, cin};
				res.flags_out = flag_word(sum9[7:0] == 8'd0, 1'b1, !nib[4], !sum9[8]);
				if (op.mode != cafu_pkg::MODE_CP) begin
					res.result_byte = sum9[7:0];
				end
			end
			cafu_pkg::MODE_AND: begin
				res.result_byte = op.acc & op.operand;
				res.flags_out = flag_word(res.result_byte == 8'd0, 1'b0, 1'b1, 1'b0);
			end
			cafu_pkg::MODE_XOR: begin
				res.result_byte = op.acc ^ op.operand;
				res.flags_out = flag_word(res.result_byte == 8'd0, 1'b0, 1'b0, 1'b0);
			end
			cafu_pkg::MODE_OR: begin
				res.result_byte = op.acc | op.operand;
				res.flags_out = flag_word(res.result_byte == 8'd0, 1'b0, 1'b0, 1'b0);
			end
			cafu_pkg::MODE_INC: begin
				res.result_byte = op.operand + 8'd1;
				res.flags_out = flag_word(res.result_byte == 8'd0, 1'b0,
					op.operand[3:0] == 4'hF, ci);
			end
			cafu_pkg::MODE_DEC: begin
				res.result_byte = op.operand - 8'd1;
				res.flags_out = flag_word(res.result_byte == 8'd0, 1'b1,
					op.operand[3:0] == 4'h0, ci);
			end
			// rotates and shifts; accumulator forms always clear zero
			cafu_pkg::MODE_RLCA, cafu_pkg::MODE_RRCA, cafu_pkg::MODE_RLA,
			cafu_pkg::MODE_RRA, cafu_pkg::MODE_RLC, cafu_pkg::MODE_RRC,
			cafu_pkg::MODE_RL, cafu_pkg::MODE_RR, cafu_pkg::MODE_SLA,
			cafu_pkg::MODE_SRA, cafu_pkg::MODE_SRL: begin
				v = (op.mode <= cafu_pkg::MODE_RRA) ? op.acc : op.operand;
				case (op.mode)
					cafu_pkg::MODE_RLCA, cafu_pkg::MODE_RLC: begin
						co = v[7];
						v  = {v[6:0], v[7]};
					end
					cafu_pkg::MODE_RRCA, cafu_pkg::MODE_RRC: begin
						co = v[0];
						v  = {v[0], v[7:1]};
					end
					cafu_pkg::MODE_RLA, cafu_pkg::MODE_RL: begin
						co = v[7];
						v  = {v[6:0], ci};
					end
					cafu_pkg::MODE_RRA, cafu_pkg::MODE_RR: begin
						co = v[0];
						v  = {ci, v[7:1]};
					end
					cafu_pkg::MODE_SLA: begin
						co = v[7];
						v  = {v[6:0], 1'b0};
					end
					cafu_pkg::MODE_SRA: begin
						co = v[0];
						v  = {v[7], v[7:1]};
					end
					default: begin
						co = v[0];
						v  = {1'b0, v[7:1]};
					end
				endcase
				res.result_byte = v;
				res.flags_out = flag_word((op.mode > cafu_pkg::MODE_RRA) && (v == 8'd0),
					1'b0, 1'b0, co);
			end
			cafu_pkg::MODE_SWAP: begin
				res.result_byte = {op.operand[3:0], op.operand[7:4]};
				res.flags_out = flag_word(res.result_byte == 8'd0, 1'b0, 1'b0, 1'b0);
			end
			cafu_pkg::MODE_BIT: begin
				res.flags_out = flag_word(!op.operand[op.bit_index], 1'b0, 1'b1, ci);
			end
			cafu_pkg::MODE_RES: begin
				res.result_byte = op.operand & ~(8'd1 << op.bit_index);
			end
			cafu_pkg::MODE_SET: begin
				res.result_byte = op.operand | (8'd1 << op.bit_index);
			end
			// decimal adjust after add or subtract
			cafu_pkg::MODE_DAA: begin
				adj = 8'd0;
				if (ni) begin
					if (hi) adj = adj + cafu_pkg::DAA_LO_ADJ;
					if (ci) adj = adj + cafu_pkg::DAA_HI_ADJ;
					res.result_byte = op.acc - adj;
					res.flags_out = flag_word(res.result_byte == 8'd0, 1'b1, 1'b0, ci);
				end else begin
					if (hi || (op.acc[3:0] > cafu_pkg::DAA_NIB_MAX)) begin
						adj = adj + cafu_pkg::DAA_LO_ADJ;
					end
					if (ci || (op.acc > cafu_pkg::DAA_ACC_MAX)) begin
						adj = adj + cafu_pkg::DAA_HI_ADJ;
					end
					sum9 = {1'b0, op.acc} + {1'b0, adj};
					res.result_byte = sum9[7:0];
					res.flags_out = flag_word(sum9[7:0] == 8'd0, 1'b0, 1'b0,
						ci || sum9[8]);
				end
			end
			cafu_pkg::MODE_CPL: begin
				res.result_byte = ~op.acc;
				res.flags_out = flag_word(zi, 1'b1, 1'b1, ci);
			end
			cafu_pkg::MODE_SCF: res.flags_out = flag_word(zi, 1'b0, 1'b0, 1'b1);
			cafu_pkg::MODE_CCF: res.flags_out = flag_word(zi, 1'b0, 1'b0, !ci);
			cafu_pkg::MODE_ADDW: begin
				sum17 = {1'b0, op.wide_left} + {1'b0, op.wide_right};
				low13 = {1'b0, op.wide_left[11:0]} + {1'b0, op.wide_right[11:0]};
				res.result_wide = sum17[15:0];
				res.flags_out = flag_word(zi, 1'b0, low13[12], sum17[16]);
			end
			// stack pointer plus signed byte; flags from the low byte
			cafu_pkg::MODE_ADDSP: begin
				res.result_wide = op.wide_left + {{8{op.operand[7]}}, op.operand};
				nib  = {1'b0, op.wide_left[3:0]} + {1'b0, op.operand[3:0]};
				sum9 = {1'b0, op.wide_left[7:0]} + {1'b0, op.operand};
				res.flags_out = flag_word(1'b0, 1'b0, nib[4], sum9[8]);
			end
			default: ;
		endcase
		return res;
	endfunction

	function automatic vec_t make_row(input logic [4:0] mode, input logic [7:0] acc,
			input logic [7:0] operand, input logic [2:0] bit_index,
			input logic [3:0] flags, input logic [15:0] wl, input logic [15:0] wr,
			input bit typed, input logic [7:0] rb, input logic [15:0] rw,
			input logic [3:0] fo);
		vec_t row;
		row.op.mode       = mode;
		row.op.acc        = acc;
		row.op.operand    = operand;
		row.op.bit_index  = bit_index;
		row.op.flags_in   = flags;
		row.op.wide_left  = wl;
		row.op.wide_right = wr;
		row.typed            = typed;
		row.want.result_byte = rb;
		row.want.result_wide = rw;
		row.want.flags_out   = fo;
		return row;
	endfunction

	// present one item and hold it until taken, then queue its expected result
	task automatic offer_item(input cafu_pkg::alu_in_t op, input cafu_pkg::alu_out_t want);
		s_tdata <= {4'd0, op.wide_right, op.wide_left, op.flags_in, op.bit_index,
			op.operand, op.acc, op.mode};
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		pending_results.push_back(want);
	endtask

	// random idle cycles on the input side
	task automatic sender_gap();
		if (!steady_phase && ($urandom_range(0, 99) < 35)) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	// stimulus
	initial begin : feed
		vec_t              directed_rows[$];
		cafu_pkg::alu_in_t op;
		int                idx;
		directed_rows.push_back(make_row(cafu_pkg::MODE_ADD, 8'hFF, 8'h01, 3'd0, 4'h0,
			16'h0000, 16'h0000, 1'b1, 8'h00, 16'h0000, 4'b1011));
		directed_rows.push_back(make_row(cafu_pkg::MODE_ADD, 8'h00, 8'h00, 3'd0, 4'h0,
			16'h0000, 16'h0000, 1'b1, 8'h00, 16'h0000, 4'b1000));
		directed_rows.push_back(make_row(cafu_pkg::MODE_ADC, 8'hFF, 8'h00, 3'd0, 4'b0001,
			16'h0000, 16'h0000, 1'b1, 8'h00, 16'h0000, 4'b1011));
		directed_rows.push_back(make_row(cafu_pkg::MODE_SUB, 8'h00, 8'h01, 3'd0, 4'h0,
			16'h0000, 16'h0000, 1'b1, 8'hFF, 16'h0000, 4'b0111));
		directed_rows.push_back(make_row(cafu_pkg::MODE_SBC, 8'h10, 8'h0F, 3'd0, 4'b0001,
			16'h0000, 16'h0000, 1'b0, 8'h00, 16'h0000, 4'h0));
		directed_rows.push_back(make_row(cafu_pkg::MODE_AND, 8'hFF, 8'h0F, 3'd0, 4'h0,
			16'h0000, 16'h0000, 1'b0, 8'h00, 16'h0000, 4'h0));
		directed_rows.push_back(make_row(cafu_pkg::MODE_XOR, 8'hAA, 8'hAA, 3'd0, 4'h0,
			16'h0000, 16'h0000, 1'b1, 8'h00, 16'h0000, 4'b1000));
		directed_rows.push_back(make_row(cafu_pkg::MODE_OR, 8'h00, 8'h00, 3'd0, 4'hF,
			16'h0000, 16'h0000, 1'b1, 8'h00, 16'h0000, 4'b1000));
		directed_rows.push_back(make_row(cafu_pkg::MODE_CP, 8'h42, 8'h42, 3'd0, 4'h0,
			16'h0000, 16'h0000, 1'b1, 8'h42, 16'h0000, 4'b1100));
		directed_rows.push_back(make_row(cafu_pkg::MODE_INC, 8'h00, 8'hFF, 3'd0, 4'b0001,
			16'h0000, 16'h0000, 1'b1, 8'h00, 16'h0000, 4'b1011));
		directed_rows.push_back(make_row(cafu_pkg::MODE_DEC, 8'h00, 8'h00, 3'd0, 4'h0,
			16'h0000, 16'h0000, 1'b1, 8'hFF, 16'h0000, 4'b0110));
		directed_rows.push_back(make_row(cafu_pkg::MODE_RLCA, 8'h80, 8'h00, 3'd0, 4'hF,
			16'h0000, 16'h0000, 1'b1, 8'h01, 16'h0000, 4'b0001));
		directed_rows.push_back(make_row(cafu_pkg::MODE_RRCA, 8'h01, 8'h00, 3'd0, 4'h0,
			16'h0000, 16'h0000, 1'b0, 8'h00, 16'h0000, 4'h0));
		directed_rows.push_back(make_row(cafu_pkg::MODE_RLA, 8'h80, 8'h00, 3'd0, 4'h0,
			16'h0000, 16'h0000, 1'b0, 8'h00, 16'h0000, 4'h0));
		directed_rows.push_back(make_row(cafu_pkg::MODE_RRA, 8'h01, 8'h00, 3'd0, 4'b0001,
			16'h0000, 16'h0000, 1'b0, 8'h00, 16'h0000, 4'h0));
		directed_rows.push_back(make_row(cafu_pkg::MODE_RLC, 8'h00, 8'h00, 3'd0, 4'h0,
			16'h0000, 16'h0000, 1'b0, 8'h00, 16'h0000, 4'h0));
		directed_rows.push_back(make_row(cafu_pkg::MODE_RRC, 8'h00, 8'h01, 3'd0, 4'h0,
			16'h0000, 16'h0000, 1'b0, 8'h00, 16'h0000, 4'h0));
		directed_rows.push_back(make_row(cafu_pkg::MODE_RL, 8'h00, 8'h80, 3'd0, 4'h0,
			16'h0000, 16'h0000, 1'b0, 8'h00, 16'h0000, 4'h0));
		directed_rows.push_back(make_row(cafu_pkg::MODE_RR, 8'h00, 8'hFF, 3'd0, 4'b0001,
			16'h0000, 16'h0000, 1'b0, 8'h00, 16'h0000, 4'h0));
		directed_rows.push_back(make_row(cafu_pkg::MODE_SLA, 8'h00, 8'h80, 3'd0, 4'h0,
			16'h0000, 16'h0000, 1'b0, 8'h00, 16'h0000, 4'h0));
		directed_rows.push_back(make_row(cafu_pkg::MODE_SRA, 8'h00, 8'h81, 3'd0, 4'h0,
			16'h0000, 16'h0000, 1'b0, 8'h00, 16'h0000, 4'h0));
		directed_rows.push_back(make_row(cafu_pkg::MODE_SWAP, 8'h00, 8'hF0, 3'd0, 4'h0,
			16'h0000, 16'h0000, 1'b0, 8'h00, 16'h0000, 4'h0));
		directed_rows.push_back(make_row(cafu_pkg::MODE_SRL, 8'h00, 8'h01, 3'd0, 4'h0,
			16'h0000, 16'h0000, 1'b0, 8'h00, 16'h0000, 4'h0));
		directed_rows.push_back(make_row(cafu_pkg::MODE_BIT, 8'h33, 8'h7F, 3'd7, 4'h0,
			16'h0000, 16'h0000, 1'b0, 8'h00, 16'h0000, 4'h0));
		directed_rows.push_back(make_row(cafu_pkg::MODE_RES, 8'h00, 8'hFF, 3'd0, 4'hF,
			16'h0000, 16'h0000, 1'b0, 8'h00, 16'h0000, 4'h0));
		directed_rows.push_back(make_row(cafu_pkg::MODE_SET, 8'h00, 8'h00, 3'd7, 4'h0,
			16'h0000, 16'h0000, 1'b0, 8'h00, 16'h0000, 4'h0));
		// decimal adjust after add with both corrections and a carry out
		directed_rows.push_back(make_row(cafu_pkg::MODE_DAA, 8'h9A, 8'h00, 3'd0, 4'h0,
			16'h0000, 16'h0000, 1'b0, 8'h00, 16'h0000, 4'h0));
		// decimal adjust after subtract with half carry and carry
		directed_rows.push_back(make_row(cafu_pkg::MODE_DAA, 8'h00, 8'h00, 3'd0, 4'b0111,
			16'h0000, 16'h0000, 1'b0, 8'h00, 16'h0000, 4'h0));
		directed_rows.push_back(make_row(cafu_pkg::MODE_CPL, 8'h00, 8'h00, 3'd0, 4'h0,
			16'h0000, 16'h0000, 1'b0, 8'h00, 16'h0000, 4'h0));
		directed_rows.push_back(make_row(cafu_pkg::MODE_SCF, 8'hFF, 8'h00, 3'd0, 4'hF,
			16'h0000, 16'h0000, 1'b0, 8'h00, 16'h0000, 4'h0));
		directed_rows.push_back(make_row(cafu_pkg::MODE_CCF, 8'h00, 8'h00, 3'd0, 4'b0001,
			16'h0000, 16'h0000, 1'b0, 8'h00, 16'h0000, 4'h0));
		directed_rows.push_back(make_row(cafu_pkg::MODE_ADDW, 8'h00, 8'h00, 3'd0, 4'b1000,
			16'hFFFF, 16'h0001, 1'b0, 8'h00, 16'h0000, 4'h0));
		directed_rows.push_back(make_row(cafu_pkg::MODE_ADDW, 8'h00, 8'h00, 3'd0, 4'h0,
			16'h0FFF, 16'h0001, 1'b0, 8'h00, 16'h0000, 4'h0));
		directed_rows.push_back(make_row(cafu_pkg::MODE_ADDSP, 8'h00, 8'h80, 3'd0, 4'hF,
			16'hFFFF, 16'h0000, 1'b0, 8'h00, 16'h0000, 4'h0));
		directed_rows.push_back(make_row(cafu_pkg::MODE_ADDSP, 8'h00, 8'h01, 3'd0, 4'h0,
			16'h000F, 16'h0000, 1'b0, 8'h00, 16'h0000, 4'h0));
		// unused code passes accumulator and flags through, with a zero wide result
		directed_rows.push_back(make_row(MODE_SPARE, 8'h5A, 8'hFF, 3'd7, 4'b1010,
			16'hFFFF, 16'hFFFF, 1'b1, 8'h5A, 16'h0000, 4'b1010));

		// hold reset, then release it
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (directed_rows[i]) begin
			sender_gap();
			offer_item(directed_rows[i].op,
				directed_rows[i].typed ? directed_rows[i].want
					: predict_alu(directed_rows[i].op));
		end

		// random items
		for (idx = 0; idx < RANDOM_ITEMS; idx++) begin
			steady_phase = (idx >= 700) && (idx < 900);
			// let the pipe drain completely once
			if (idx == 1100) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
				while (pending_results.size() != 0) @(posedge clk);
			end
			sender_gap();
			op.mode       = 5'($urandom_range(0, 31));
			op.acc        = 8'($urandom);
			op.operand    = 8'($urandom);
			op.bit_index  = 3'($urandom);
			op.flags_in   = 4'($urandom);
			op.wide_left  = 16'($urandom);
			op.wide_right = 16'($urandom);
			offer_item(op, predict_alu(op));
		end
		s_tvalid <= 1'b0;
		@(posedge clk);

		// wait for the last results, then a few more cycles
		while (pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("cpu_8bit_alu_flags_unit: match");
		end else begin
			$display("cpu_8bit_alu_flags_unit: mismatch");
		end
		$finish;
	end

	// result side: compare each item, then pick the next ready level
	initial begin : drain
		cafu_pkg::alu_out_t got;
		cafu_pkg::alu_out_t want;
		int                 hold_left;
		int                 rx_count;
		bit                 hold_done;
		hold_left = 0;
		rx_count  = 0;
		hold_done = 1'b0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				got.result_byte = m_tdata[7:0];
				got.result_wide = m_tdata[23:8];
				got.flags_out   = m_tdata[27:24];
				rx_count++;
				if (pending_results.size() == 0) begin
					mismatch_count++;
					$display("%0t: unexpected item byte=%h wide=%h flags=%b", $time,
						got.result_byte, got.result_wide, got.flags_out);
				end else begin
					want = pending_results.pop_front();
					if (got !== want) begin
						mismatch_count++;
						$display("%0t: expected byte=%h wide=%h flags=%b, %s",
							$time, want.result_byte, want.result_wide, want.flags_out,
							$sformatf("got byte=%h wide=%h flags=%b",
								got.result_byte, got.result_wide, got.flags_out));
					end
				end
			end
			// one long hold-off so the input side backs up
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (!hold_done && (rx_count >= 400)) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
				m_tready <= 1'b0;
			end else if (steady_phase) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= 35);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("cpu_8bit_alu_flags_unit: mismatch");
			$finish;
		end
	end

endmodule
